[hdl/imu_m2c_pkg.sv]
// Shared constants, register codes and pipeline types of the motion-to-cursor mapper.
package imu_m2c_pkg;

  // Sample format.
  localparam int READING_BITS  = 17;
  localparam int FRACTION_BITS = 10;
  localparam int MAG_W         = READING_BITS;

  // Register widths.
  localparam int MODE_W   = 2;
  localparam int GAIN_W   = 16;
  localparam int TDZ_W    = 16;
  localparam int THR_W    = 20;
  localparam int LIM_W    = 7;
  localparam int DELTA_W  = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_POINTER_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_DEAD_ZONE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_DEAD_ZONE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_THRESHOLD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_LIMIT     = 3'd7;

  // Pointer modes; the unused code behaves as off.
  localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TILT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GYRO = 2'd2;

  // Reset values of the registers.
  localparam logic [MODE_W-1:0] RST_POINTER_MODE   = MODE_OFF;
  localparam logic [TDZ_W-1:0]  RST_TILT_DEAD_ZONE = 16'd154;
  localparam logic [GAIN_W-1:0] RST_TILT_GAIN      = 16'd768;
  localparam logic [LIM_W-1:0]  RST_TILT_LIMIT     = 7'd15;
  localparam logic [THR_W-1:0]  RST_GYRO_DEAD_ZONE = 20'd2048;
  localparam logic [GAIN_W-1:0] RST_GYRO_GAIN      = 16'd246;
  localparam logic [THR_W-1:0]  RST_GYRO_THRESHOLD = 20'd30720;
  localparam logic [LIM_W-1:0]  RST_GYRO_LIMIT     = 7'd50;

  // Radians to degrees in Q16, and the Q12 acceleration multiplier.
  localparam int RAD_W = 22;
  localparam logic [RAD_W-1:0] RAD2DEG_Q16 = 22'd3754936;
  localparam int M_W   = 14;
  localparam logic [M_W-1:0] MULT_ONE = 14'd4096;
  localparam logic [M_W-1:0] MULT_CAP = 14'd10240;

  // Derived datapath widths.
  localparam int PROD_W = MAG_W + RAD_W;
  localparam int D_W    = PROD_W - 16;
  localparam int CMP_W  = (D_W > THR_W + 1) ? D_W : THR_W + 1;
  localparam int TR_W   = PROD_W - 8 - FRACTION_BITS;
  localparam int QUO_W  = 13;
  localparam int NUM_W  = THR_W + QUO_W;
  localparam int DIV_STAGES = QUO_W;
  localparam int TP_W   = D_W + M_W;
  localparam int T_W    = D_W + 2;
  localparam int GP_W   = T_W + GAIN_W;
  localparam int GR_W   = GP_W - 12 - FRACTION_BITS;
  localparam int LANES  = 2;

  // Per-lane contents of the pipeline stages.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } s0_lane_t;

  typedef struct packed {
    logic              neg;
    logic              tilt_dz;
    logic [PROD_W-1:0] prod;
  } s1_lane_t;

  typedef struct packed {
    logic             neg;
    logic [LIM_W-1:0] tilt_mag;
    logic             gyro_zero;
    logic             le;
    logic             ge;
    logic [D_W-1:0]   d;
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic             neg;
    logic [LIM_W-1:0] tilt_mag;
    logic             gyro_zero;
    logic [TP_W-1:0]  tprod;
  } sm_lane_t;

  typedef struct packed {
    logic             neg;
    logic [LIM_W-1:0] tilt_mag;
    logic             gyro_zero;
    logic [GP_W-1:0]  gprod;
  } sg_lane_t;

endpackage

[hdl/imu_m2c_if.sv]
// Valid/ready channel interfaces for sensor samples and cursor deltas.
interface imu_m2c_in_if;
  logic valid;
  logic ready;
  logic signed [imu_m2c_pkg::READING_BITS-1:0] x_reading;
  logic signed [imu_m2c_pkg::READING_BITS-1:0] y_reading;

  modport source (output valid, output x_reading, output y_reading, input ready);
  modport sink (input valid, input x_reading, input y_reading, output ready);
endinterface

interface imu_m2c_out_if;
  logic valid;
  logic ready;
  logic signed [imu_m2c_pkg::DELTA_W-1:0] delta_x;
  logic signed [imu_m2c_pkg::DELTA_W-1:0] delta_y;

  modport source (output valid, output delta_x, output delta_y, input ready);
  modport sink (input valid, input delta_x, input delta_y, output ready);
endinterface

[hdl/imu_motion_to_cursor_delta.sv]
// Air-mouse mapper: X/Y motion samples to signed cursor deltas.
//
// Usage:
//   in_ch  carries one X/Y sample pair per transaction (valid/ready).
//   out_ch carries one delta pair per transaction; a sample whose deltas
//          are both zero, or any sample while the mode is off, produces none.
//   cfg_*  writes one register per cycle while cfg_we is high; write only
//          while no sample is in flight.
// Timing:
//   The datapath is 19 register stages: input capture, shared multiplier,
//   dead-zone and boost-region compare, 13 one-bit divider stages for the
//   boost slope, multiplier, gain multiplier and the output register. One
//   sample is accepted every cycle unless a finished result waits on a
//   low out_ch.ready.
// Reset and stall:
//   Synchronous reset empties the pipeline and loads the register defaults.
//   When out_ch.ready is low while a result waits, the whole pipeline holds
//   and in_ch.ready drops; nothing is lost or repeated.
module imu_motion_to_cursor_delta (
  input  logic                                 clk,
  input  logic                                 rst_n,
  imu_m2c_in_if.sink                           in_ch,
  imu_m2c_out_if.source                        out_ch,
  input  logic                                 cfg_we,
  input  logic [imu_m2c_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [imu_m2c_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int LANES = imu_m2c_pkg::LANES;
  localparam int DIVS  = imu_m2c_pkg::DIV_STAGES;

  // Configuration registers.
  logic [imu_m2c_pkg::MODE_W-1:0] mode_r;
  logic [imu_m2c_pkg::TDZ_W-1:0]  tilt_dz_r;
  logic [imu_m2c_pkg::GAIN_W-1:0] tilt_gain_r;
  logic [imu_m2c_pkg::LIM_W-1:0]  tilt_lim_r;
  logic [imu_m2c_pkg::THR_W-1:0]  gyro_dz_r;
  logic [imu_m2c_pkg::GAIN_W-1:0] gyro_gain_r;
  logic [imu_m2c_pkg::THR_W-1:0]  gyro_thr_r;
  logic [imu_m2c_pkg::LIM_W-1:0]  gyro_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= imu_m2c_pkg::RST_POINTER_MODE;
      tilt_dz_r   <= imu_m2c_pkg::RST_TILT_DEAD_ZONE;
      tilt_gain_r <= imu_m2c_pkg::RST_TILT_GAIN;
      tilt_lim_r  <= imu_m2c_pkg::RST_TILT_LIMIT;
      gyro_dz_r   <= imu_m2c_pkg::RST_GYRO_DEAD_ZONE;
      gyro_gain_r <= imu_m2c_pkg::RST_GYRO_GAIN;
      gyro_thr_r  <= imu_m2c_pkg::RST_GYRO_THRESHOLD;
      gyro_lim_r  <= imu_m2c_pkg::RST_GYRO_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        imu_m2c_pkg::CFG_POINTER_MODE:   mode_r      <= cfg_data[imu_m2c_pkg::MODE_W-1:0];
        imu_m2c_pkg::CFG_TILT_DEAD_ZONE: tilt_dz_r   <= cfg_data[imu_m2c_pkg::TDZ_W-1:0];
        imu_m2c_pkg::CFG_TILT_GAIN:      tilt_gain_r <= cfg_data[imu_m2c_pkg::GAIN_W-1:0];
        imu_m2c_pkg::CFG_TILT_LIMIT:     tilt_lim_r  <= cfg_data[imu_m2c_pkg::LIM_W-1:0];
        imu_m2c_pkg::CFG_GYRO_DEAD_ZONE: gyro_dz_r   <= cfg_data[imu_m2c_pkg::THR_W-1:0];
        imu_m2c_pkg::CFG_GYRO_GAIN:      gyro_gain_r <= cfg_data[imu_m2c_pkg::GAIN_W-1:0];
        imu_m2c_pkg::CFG_GYRO_THRESHOLD: gyro_thr_r  <= cfg_data[imu_m2c_pkg::THR_W-1:0];
        imu_m2c_pkg::CFG_GYRO_LIMIT:     gyro_lim_r  <= cfg_data[imu_m2c_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline registers.
  logic                                    out_valid_r;
  logic signed [imu_m2c_pkg::DELTA_W-1:0] dx_r, dx_nxt;
  logic signed [imu_m2c_pkg::DELTA_W-1:0] dy_r, dy_nxt;
  logic                                    out_valid_nxt;
  logic                                    s0_valid_r, s1_valid_r, sm_valid_r, sg_valid_r;
  logic [DIVS:0]                           div_valid_r;
  imu_m2c_pkg::s0_lane_t  s0_r  [LANES];
  imu_m2c_pkg::s0_lane_t  s0_nxt[LANES];
  imu_m2c_pkg::s1_lane_t  s1_r  [LANES];
  imu_m2c_pkg::s1_lane_t  s1_nxt[LANES];
  imu_m2c_pkg::div_lane_t div_r [DIVS+1][LANES];
  imu_m2c_pkg::div_lane_t div_nxt[DIVS+1][LANES];
  imu_m2c_pkg::sm_lane_t  sm_r  [LANES];
  imu_m2c_pkg::sm_lane_t  sm_nxt[LANES];
  imu_m2c_pkg::sg_lane_t  sg_r  [LANES];
  imu_m2c_pkg::sg_lane_t  sg_nxt[LANES];

  // The whole pipeline advances unless a finished result is held up.
  logic pipe_en;
  assign pipe_en      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = pipe_en;
  assign out_ch.valid = out_valid_r;
  assign out_ch.delta_x = dx_r;
  assign out_ch.delta_y = dy_r;

  // Stage 0: the reading as sign and magnitude.
  logic signed [imu_m2c_pkg::READING_BITS-1:0] reading [LANES];
  assign reading[0] = in_ch.x_reading;
  assign reading[1] = in_ch.y_reading;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      s0_nxt[l].neg = reading[l][imu_m2c_pkg::READING_BITS-1];
      s0_nxt[l].mag = s0_nxt[l].neg ? imu_m2c_pkg::MAG_W'(-reading[l])
                                    : imu_m2c_pkg::MAG_W'(reading[l]);
    end
  end

  // Stage 1: one multiplier per lane, tilt gain or radian conversion.
  logic [imu_m2c_pkg::RAD_W-1:0] mul_coef;
  assign mul_coef = (mode_r == imu_m2c_pkg::MODE_TILT) ?
                    imu_m2c_pkg::RAD_W'(tilt_gain_r) : imu_m2c_pkg::RAD2DEG_Q16;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      s1_nxt[l].neg     = s0_r[l].neg;
      s1_nxt[l].tilt_dz = s0_r[l].mag < imu_m2c_pkg::MAG_W'(tilt_dz_r);
      s1_nxt[l].prod    = imu_m2c_pkg::PROD_W'(s0_r[l].mag) *
                          imu_m2c_pkg::PROD_W'(mul_coef);
    end
  end

  // Stage 2: tilt result, gyro dead zone, boost region and slope numerator.
  logic [imu_m2c_pkg::TR_W-1:0]  tilt_raw [LANES];
  logic [imu_m2c_pkg::CMP_W-1:0] d_cmp    [LANES];
  logic [imu_m2c_pkg::THR_W-1:0] excess   [LANES];
  logic [imu_m2c_pkg::CMP_W-1:0] thr_cmp, thr2_cmp;

  assign thr_cmp  = imu_m2c_pkg::CMP_W'(gyro_thr_r);
  assign thr2_cmp = imu_m2c_pkg::CMP_W'({gyro_thr_r, 1'b0});

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      tilt_raw[l] = s1_r[l].prod[imu_m2c_pkg::PROD_W-1:8+imu_m2c_pkg::FRACTION_BITS];
      d_cmp[l]    = imu_m2c_pkg::CMP_W'(s1_r[l].prod[imu_m2c_pkg::PROD_W-1:16]);
      excess[l]   = imu_m2c_pkg::THR_W'(d_cmp[l] - thr_cmp);
      div_nxt[0][l].neg = s1_r[l].neg;
      if (s1_r[l].tilt_dz) begin
        div_nxt[0][l].tilt_mag = '0;
      end else if (tilt_raw[l] > imu_m2c_pkg::TR_W'(tilt_lim_r)) begin
        div_nxt[0][l].tilt_mag = tilt_lim_r;
      end else begin
        div_nxt[0][l].tilt_mag = imu_m2c_pkg::LIM_W'(tilt_raw[l]);
      end
      div_nxt[0][l].gyro_zero = d_cmp[l] < imu_m2c_pkg::CMP_W'(gyro_dz_r);
      div_nxt[0][l].le  = d_cmp[l] <= thr_cmp;
      div_nxt[0][l].ge  = d_cmp[l] >= thr2_cmp;
      div_nxt[0][l].d   = s1_r[l].prod[imu_m2c_pkg::PROD_W-1:16];
      // 6144 * excess, as (excess << 12) + (excess << 11).
      div_nxt[0][l].rem = (imu_m2c_pkg::NUM_W'(excess[l]) << 12) +
                          (imu_m2c_pkg::NUM_W'(excess[l]) << 11);
      div_nxt[0][l].quo = '0;
    end

    // Divider stages: one quotient bit each, most significant first.
    // The numerator stays below 6144 * threshold, so 13 bits suffice.
    for (int s = 1; s <= DIVS; s++) begin
      for (int l = 0; l < LANES; l++) begin
        div_nxt[s][l] = div_r[s-1][l];
        if (div_r[s-1][l].rem >= (imu_m2c_pkg::NUM_W'(gyro_thr_r) << (DIVS - s))) begin
          div_nxt[s][l].rem = div_r[s-1][l].rem -
                              (imu_m2c_pkg::NUM_W'(gyro_thr_r) << (DIVS - s));
          div_nxt[s][l].quo[DIVS - s] = 1'b1;
        end
      end
    end
  end

  // Multiplier stage: select the Q12 multiplier and scale the rate.
  logic [imu_m2c_pkg::M_W-1:0] mult [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (div_r[DIVS][l].le) begin
        mult[l] = imu_m2c_pkg::MULT_ONE;
      end else if (div_r[DIVS][l].ge) begin
        mult[l] = imu_m2c_pkg::MULT_CAP;
      end else begin
        mult[l] = imu_m2c_pkg::MULT_ONE + imu_m2c_pkg::M_W'(div_r[DIVS][l].quo);
      end
      sm_nxt[l].neg       = div_r[DIVS][l].neg;
      sm_nxt[l].tilt_mag  = div_r[DIVS][l].tilt_mag;
      sm_nxt[l].gyro_zero = div_r[DIVS][l].gyro_zero;
      sm_nxt[l].tprod     = imu_m2c_pkg::TP_W'(div_r[DIVS][l].d) *
                            imu_m2c_pkg::TP_W'(mult[l]);
    end
  end

  // Gain stage: drop the Q12 fraction and apply the gyro gain.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sg_nxt[l].neg       = sm_r[l].neg;
      sg_nxt[l].tilt_mag  = sm_r[l].tilt_mag;
      sg_nxt[l].gyro_zero = sm_r[l].gyro_zero;
      sg_nxt[l].gprod     = imu_m2c_pkg::GP_W'(sm_r[l].tprod[imu_m2c_pkg::TP_W-1:12]) *
                            imu_m2c_pkg::GP_W'(gyro_gain_r);
    end
  end

  // Output stage: clamp, pick the mode, apply the inverted sign of the reading and drop empty results.
  logic [imu_m2c_pkg::GR_W-1:0]  gyro_raw [LANES];
  logic [imu_m2c_pkg::LIM_W-1:0] gyro_mag [LANES];
  logic [imu_m2c_pkg::LIM_W-1:0] fin_mag  [LANES];
  logic [imu_m2c_pkg::DELTA_W-1:0] fin_delta [LANES];
  logic mode_active;

  assign mode_active = (mode_r == imu_m2c_pkg::MODE_TILT) ||
                       (mode_r == imu_m2c_pkg::MODE_GYRO);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      gyro_raw[l] = sg_r[l].gprod[imu_m2c_pkg::GP_W-1:12+imu_m2c_pkg::FRACTION_BITS];
      if (sg_r[l].gyro_zero) begin
        gyro_mag[l] = '0;
      end else if (gyro_raw[l] > imu_m2c_pkg::GR_W'(gyro_lim_r)) begin
        gyro_mag[l] = gyro_lim_r;
      end else begin
        gyro_mag[l] = imu_m2c_pkg::LIM_W'(gyro_raw[l]);
      end
      fin_mag[l] = (mode_r == imu_m2c_pkg::MODE_TILT) ? sg_r[l].tilt_mag : gyro_mag[l];
      fin_delta[l] = sg_r[l].neg ? imu_m2c_pkg::DELTA_W'(fin_mag[l])
                                 : imu_m2c_pkg::DELTA_W'(-{1'b0, fin_mag[l]});
    end
    dx_nxt        = fin_delta[0];
    dy_nxt        = fin_delta[1];
    out_valid_nxt = sg_valid_r && mode_active && ((fin_mag[0] != '0) || (fin_mag[1] != '0));
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      div_valid_r <= '0;
      sm_valid_r  <= 1'b0;
      sg_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s0_valid_r  <= in_ch.valid;
      s1_valid_r  <= s0_valid_r;
      div_valid_r <= {div_valid_r[DIVS-1:0], s1_valid_r};
      sm_valid_r  <= div_valid_r[DIVS];
      sg_valid_r  <= sm_valid_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers move on the same enable and need no reset.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int l = 0; l < LANES; l++) begin
        s0_r[l] <= s0_nxt[l];
        s1_r[l] <= s1_nxt[l];
        for (int s = 0; s <= DIVS; s++) begin
          div_r[s][l] <= div_nxt[s][l];
        end
        sm_r[l] <= sm_nxt[l];
        sg_r[l] <= sg_nxt[l];
      end
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
  end

endmodule

[hdl/imu_m2c_checker.sv]
// Port-level checker for the motion-to-cursor mapper, bound to the top level.
module imu_m2c_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [imu_m2c_pkg::DELTA_W-1:0] delta_x,
  input logic signed [imu_m2c_pkg::DELTA_W-1:0] delta_y
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its deltas.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(delta_x) && $stable(delta_y))
    else $error("result changed while stalled");

  // Empty results are never delivered.
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (delta_x != 0 || delta_y != 0))
    else $error("all-zero delta pair delivered");

  // Clamped magnitudes never reach the most negative code.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (delta_x != -8'sd128 && delta_y != -8'sd128))
    else $error("delta outside the clamp range");

  // With no result waiting the block must take samples.
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with an empty output");

endmodule

bind imu_motion_to_cursor_delta imu_m2c_checker u_imu_m2c_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .delta_x   (out_ch.delta_x),
  .delta_y   (out_ch.delta_y)
);
